[rtl/tpag_pkg.sv]
// Package for the padded-tensor address generator.
// Holds sizes, config and queue entry types and the field helpers.
// No dependencies.
package tpag_pkg;

  localparam int MAX_DIMS    = 4;
  localparam int SIZE_WIDTH  = 16;
  localparam int ADDR_WIDTH  = 32;

  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int DIMS_W      = 3;
  localparam int MAP_W       = 16;
  localparam int VALUE_W     = 32;
  localparam int DEST_ADDR_W = 32;

  localparam int DIM_CNT_W   = $clog2(MAX_DIMS + 1);
  localparam int DIM_IDX_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PROD_W      = ADDR_WIDTH + SIZE_WIDTH + 1;

  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_SIZES = 3'd0,
    CFG_DEST_SIZES   = 3'd1,
    CFG_PAD_OFFSETS  = 3'd2,
    CFG_DIMS_IN_USE  = 3'd3,
    CFG_MAP_COUNT    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAC,
    BK_FIN
  } bk_state_e;

  typedef logic [MAX_DIMS-1:0][SIZE_WIDTH-1:0] pos_t;

  typedef struct packed {
    logic [CFG_W-1:0]  source_sizes;
    logic [CFG_W-1:0]  dest_sizes;
    logic [CFG_W-1:0]  pad_offsets;
    logic [DIMS_W-1:0] dims_in_use;
    logic [MAP_W-1:0]  map_count;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    pos_t               pos;
    logic               wrap;
    logic               done;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Extent or padding of dimension idx from a packed register.
  function automatic logic [SIZE_WIDTH-1:0] field_of(logic [CFG_W-1:0] packed_v,
                                                     logic [DIM_IDX_W-1:0] idx);
    return packed_v[idx * SIZE_WIDTH +: SIZE_WIDTH];
  endfunction

  // Clamp the dimension count into 1..MAX_DIMS.
  function automatic logic [DIM_CNT_W-1:0] used_dims(logic [DIMS_W-1:0] dims);
    logic [DIM_CNT_W-1:0] d;
    if (dims == '0) begin
      d = DIM_CNT_W'(1);
    end else if (32'(dims) > MAX_DIMS) begin
      d = DIM_CNT_W'(MAX_DIMS);
    end else begin
      d = DIM_CNT_W'(dims);
    end
    return d;
  endfunction

endpackage

[rtl/tpag_front.sv]
// Front end: accepts source words and steps the position and map counters.
// Pushes each word with its position snapshot into the queue. Uses tpag_pkg.
module tpag_front import tpag_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VALUE_W-1:0] elem_value_i,
  input  q_stat_t            q_stat_i,
  output logic               push_o,
  output qent_t              push_data_o
);

  pos_t             pos_q, pos_d;
  logic [MAP_W-1:0] map_q, map_d;
  logic [DIM_CNT_W-1:0] d_used;

  assign d_used     = used_dims(cfg_i.dims_in_use);
  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    logic [SIZE_WIDTH:0] nx;
    logic [MAP_W:0]      mnx;
    logic                carry;
    logic                done;
    pos_d = pos_q;
    map_d = map_q;
    carry = 1'b1;
    done  = 1'b0;
    nx    = '0;
    mnx   = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if ((DIM_CNT_W'(i) < d_used) && carry) begin
        nx = {1'b0, pos_q[i]} + 1'b1;
        if (nx >= {1'b0, field_of(cfg_i.source_sizes, DIM_IDX_W'(i))}) begin
          pos_d[i] = '0;
        end else begin
          pos_d[i] = nx[SIZE_WIDTH-1:0];
          carry    = 1'b0;
        end
      end
    end
    if (carry) begin
      mnx = {1'b0, map_q} + 1'b1;
      if (mnx >= {1'b0, cfg_i.map_count}) begin
        done  = 1'b1;
        map_d = '0;
        pos_d = '0;
      end else begin
        map_d = mnx[MAP_W-1:0];
      end
    end
    push_data_o.value = elem_value_i;
    push_data_o.pos   = pos_q;
    push_data_o.wrap  = carry;
    push_data_o.done  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      map_q <= '0;
    end else if (push_o) begin
      pos_q <= pos_d;
      map_q <= map_d;
    end
  end

endmodule

[rtl/tpag_queue.sv]
// Two-entry queue between front and back ends.
// Head entry is read from registers. Uses tpag_pkg.
module tpag_queue import tpag_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  qent_t   push_data_i,
  input  logic    pop_i,
  output qent_t   head_o,
  output q_stat_t stat_o
);

  qent_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q;

  assign stat_o.full  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [Q_PTR_W-1:0] ptr_inc(logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= Q_DEPTH)
    else $error("queue count above depth");

endmodule

[rtl/tpag_back.sv]
// Back end: Horner address evaluation over the used dimensions, plane base
// tracking and the output register. Uses tpag_pkg.
module tpag_back import tpag_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  qent_t                  head_i,
  input  q_stat_t                q_stat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DEST_ADDR_W-1:0] dest_address_o,
  output logic [VALUE_W-1:0]     dest_value_o,
  output logic                   tensor_done_o,
  output logic                   size_error_o
);

  bk_state_e            state_q, state_d;
  logic [DIM_IDX_W-1:0] idx_q, idx_d;
  logic [ADDR_WIDTH-1:0] acc_q, acc_d, plane_q, plane_d, base_q, base_d;
  qent_t                item_q, item_d;
  logic                 out_valid_q, out_valid_d, out_load;
  logic [DEST_ADDR_W-1:0] addr_q;
  logic [VALUE_W-1:0]   value_q;
  logic                 done_q, err_q, size_err;
  logic [DIM_CNT_W-1:0] d_used;
  logic [PROD_W-1:0]    acc_prod, plane_prod, acc_sum;
  logic [SIZE_WIDTH-1:0] dest_f, pad_f;

  assign d_used = used_dims(cfg_i.dims_in_use);
  assign dest_f = field_of(cfg_i.dest_sizes, idx_q);
  assign pad_f  = field_of(cfg_i.pad_offsets, idx_q);

  assign acc_prod   = PROD_W'(acc_q) * PROD_W'(dest_f);
  assign plane_prod = PROD_W'(plane_q) * PROD_W'(dest_f);
  assign acc_sum    = acc_prod + PROD_W'(item_q.pos[idx_q]) + PROD_W'(pad_f);

  // Size check over the used dimensions, at full width.
  always_comb begin
    size_err = 1'b0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if ((DIM_CNT_W'(i) < d_used) &&
          (({1'b0, field_of(cfg_i.source_sizes, DIM_IDX_W'(i))} +
            {1'b0, field_of(cfg_i.pad_offsets, DIM_IDX_W'(i))}) >
           {1'b0, field_of(cfg_i.dest_sizes, DIM_IDX_W'(i))})) begin
        size_err = 1'b1;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    plane_d  = plane_q;
    base_d   = base_q;
    item_d   = item_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          item_d  = head_i;
          idx_d   = DIM_IDX_W'(d_used - 1'b1);
          acc_d   = '0;
          plane_d = ADDR_WIDTH'(1);
          state_d = BK_MAC;
        end
      end
      BK_MAC: begin
        acc_d   = acc_sum[ADDR_WIDTH-1:0];
        plane_d = plane_prod[ADDR_WIDTH-1:0];
        if (idx_q == '0) begin
          state_d = BK_FIN;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      BK_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
          if (item_q.done) begin
            base_d = '0;
          end else if (item_q.wrap) begin
            base_d = base_q + plane_q;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    acc_q   <= acc_d;
    plane_q <= plane_d;
    item_q  <= item_d;
    if (out_load) begin
      addr_q  <= DEST_ADDR_W'(acc_q + base_q);
      value_q <= item_q.value;
      done_q  <= item_q.done;
      err_q   <= size_err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_address_o = addr_q;
  assign dest_value_o   = value_q;
  assign tensor_done_o  = done_q;
  assign size_error_o   = err_q;

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FIN && !out_valid_q) |=> out_valid_q)
    else $error("finished word not loaded into output");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MAC) |-> (DIM_CNT_W'(idx_q) < d_used))
    else $error("dimension index beyond used dimensions");

  a_base_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && item_q.done) |=> (base_q == '0))
    else $error("plane base not cleared at end of tensor");

endmodule

[rtl/tensor_pad_address_generator_top.sv]
// Padded-tensor address generator, top level. The back end takes one word
// at a time from the queue and evaluates it with a single multiply-accumulate
// step per dimension over the d used dimensions (1..4), then loads the result
// register; the two-entry queue lets input words arrive while the back end
// works or a result waits. Reset clears the position and map counters, the
// plane base and the queue; config resets to zero extents.
module tensor_pad_address_generator_top import tpag_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // source words
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_W-1:0]     elem_value_i,
  // result words
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DEST_ADDR_W-1:0] dest_address_o,
  output logic [VALUE_W-1:0]     dest_value_o,
  output logic                   tensor_done_o,
  output logic                   size_error_o
);

  cfg_t    cfg_q;
  q_stat_t q_stat;
  logic    push, pop;
  qent_t   push_data, head;

  // Config registers; writes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_sizes <= '0;
      cfg_q.dest_sizes   <= '0;
      cfg_q.pad_offsets  <= '0;
      cfg_q.dims_in_use  <= DIMS_W'(1);
      cfg_q.map_count    <= MAP_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SOURCE_SIZES: cfg_q.source_sizes <= cfg_wdata_i;
        CFG_DEST_SIZES:   cfg_q.dest_sizes   <= cfg_wdata_i;
        CFG_PAD_OFFSETS:  cfg_q.pad_offsets  <= cfg_wdata_i;
        CFG_DIMS_IN_USE:  cfg_q.dims_in_use  <= cfg_wdata_i[DIMS_W-1:0];
        CFG_MAP_COUNT:    cfg_q.map_count    <= cfg_wdata_i[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: advance counters per accepted word, tag wrap and end of tensor.
  tpag_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .elem_value_i (elem_value_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Hold words between the two ends so each can stall on its own.
  tpag_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  // Back end: evaluate the address, track the plane base, drive results.
  tpag_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (head),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dest_address_o (dest_address_o),
    .dest_value_o   (dest_value_o),
    .tensor_done_o  (tensor_done_o),
    .size_error_o   (size_error_o)
  );

endmodule
